FILE: rtl/core/psb_pkg.sv
// ----------------------------------------------------------------------------
// psb_pkg
// Shared types, constants and helpers for the prime sieve bitmap block.
// ----------------------------------------------------------------------------
package psb_pkg;

  localparam int WORD_W  = 32;
  localparam int CNT_W   = 13;
  localparam int NUM_W   = 16;
  localparam int PRIME_W = 9;   // sieving primes stay at or below 257

  // command codes
  localparam logic CMD_SIEVE = 1'b0;
  localparam logic CMD_TEST  = 1'b1;

  // word 0 after a fill: numbers 0 and 1 are not prime
  localparam logic [WORD_W-1:0] FILL_WORD0 = 32'hFFFF_FFFC;
  localparam logic [WORD_W-1:0] FILL_WORD  = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_PRD,
    ST_PCHK,
    ST_MCLR,
    ST_CRD,
    ST_CACC,
    ST_TRD,
    ST_TCHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] prime_count;
    logic             is_prime;
  } res_t;

  function automatic logic [5:0] popcount32(input logic [WORD_W-1:0] w);
    logic [5:0] s;
    s = '0;
    for (int i = 0; i < WORD_W; i++) begin
      s = s + 6'(w[i]);
    end
    return s;
  endfunction

endpackage

FILE: rtl/core/psb_ram.sv
// ----------------------------------------------------------------------------
// psb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module psb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/psb_sieve_ctrl.sv
// ----------------------------------------------------------------------------
// psb_sieve_ctrl
// Sequencer for fill, mark, count and test; drives the bitmap RAM.
// ----------------------------------------------------------------------------
module psb_sieve_ctrl
  import psb_pkg::*;
#(
  parameter int BITMAP_WORDS = 2048
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_command,
  input  logic [NUM_W-1:0]          in_limit,
  input  logic [NUM_W-1:0]          in_value,
  output logic                      res_valid,
  output res_t                      res,
  input  logic                      res_take,
  output logic                      mem_we,
  output logic [(BITMAP_WORDS > 1 ? $clog2(BITMAP_WORDS) : 1)-1:0] mem_waddr,
  output logic [WORD_W-1:0]         mem_wdata,
  output logic [(BITMAP_WORDS > 1 ? $clog2(BITMAP_WORDS) : 1)-1:0] mem_raddr,
  input  logic [WORD_W-1:0]         mem_rdata
);

  localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int BW = (AW + 6 > 18) ? AW + 6 : 18;
  localparam logic [BW-1:0] TOTAL_BITS = BW'(BITMAP_WORDS * 32);
  localparam logic [AW-1:0] LAST_WORD  = AW'(BITMAP_WORDS - 1);

  state_t              state_r, state_nxt;
  logic [PRIME_W-1:0]  p_r, p_nxt;
  logic [BW-1:0]       m_r, m_nxt;
  logic [BW-1:0]       top_r, top_nxt;
  logic [BW-1:0]       ctop_r, ctop_nxt;
  logic [BW-1:0]       nb_r, nb_nxt;
  logic [AW-1:0]       fidx_r, fidx_nxt;
  logic [NUM_W-1:0]    val_r, val_nxt;
  logic [WORD_W-1:0]   wd_r, wd_nxt;
  logic                first_r, first_nxt;
  logic                filled_r, filled_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  res_t                res_r, res_nxt;

  logic                accept;
  logic [BW-1:0]       limit_x, value_x, p_x, pp_x, m_step, nb_step, rem;
  logic [2*PRIME_W-1:0] pp;
  logic                pp_over, mark_more, mark_same, cnt_last, fill_last;
  logic [WORD_W-1:0]   mark_w, mark_w_new, cnt_mask;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

  assign limit_x   = BW'(in_limit);
  assign value_x   = BW'(val_r);
  assign p_x       = BW'(p_r);
  assign pp        = p_r * p_r;
  assign pp_x      = BW'(pp);
  assign pp_over   = (pp_x > top_r);

  assign mark_w     = first_r ? mem_rdata : wd_r;
  assign mark_w_new = mark_w & ~(WORD_W'(1) << m_r[4:0]);
  assign m_step     = m_r + p_x;
  assign mark_more  = (m_step <= top_r);
  assign mark_same  = (m_step[BW-1:5] == m_r[BW-1:5]);

  assign rem      = ctop_r - nb_r;
  assign cnt_mask = (rem >= BW'(WORD_W)) ? FILL_WORD :
                    ((WORD_W'(1) << rem[4:0]) - WORD_W'(1));
  assign nb_step  = nb_r + BW'(WORD_W);
  assign cnt_last = (nb_step >= ctop_r);

  assign fill_last = (fidx_r == LAST_WORD);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_command == CMD_TEST) ? ST_TRD : ST_FILL;
        end
      end
      ST_FILL: if (fill_last) state_nxt = ST_PRD;
      ST_PRD: begin
        if (!pp_over) begin
          state_nxt = ST_PCHK;
        end else if (ctop_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_CRD;
        end
      end
      ST_PCHK: state_nxt = mem_rdata[p_r[4:0]] ? ST_MCLR : ST_PRD;
      ST_MCLR: if (!mark_more) state_nxt = ST_PRD;
      ST_CRD:  state_nxt = ST_CACC;
      ST_CACC: state_nxt = cnt_last ? ST_DONE : ST_CRD;
      ST_TRD:  state_nxt = ST_TCHK;
      ST_TCHK: state_nxt = ST_DONE;
      ST_DONE: if (res_take) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and RAM controls
  always_comb begin
    p_nxt      = p_r;
    m_nxt      = m_r;
    top_nxt    = top_r;
    ctop_nxt   = ctop_r;
    nb_nxt     = nb_r;
    fidx_nxt   = fidx_r;
    val_nxt    = val_r;
    wd_nxt     = wd_r;
    first_nxt  = first_r;
    filled_nxt = filled_r;
    cnt_nxt    = cnt_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_raddr  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_command)
            CMD_SIEVE: begin
              top_nxt    = (limit_x > TOTAL_BITS - BW'(1)) ? TOTAL_BITS - BW'(1) : limit_x;
              ctop_nxt   = (limit_x > TOTAL_BITS) ? TOTAL_BITS : limit_x;
              fidx_nxt   = '0;
              filled_nxt = 1'b1;
            end
            CMD_TEST: val_nxt = in_value;
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fidx_r;
        mem_wdata = (fidx_r == '0) ? FILL_WORD0 : FILL_WORD;
        fidx_nxt  = fidx_r + AW'(1);
        p_nxt     = PRIME_W'(2);
      end
      ST_PRD: begin
        // issue read of the word holding p, or set up the count pass
        mem_raddr = p_x[AW+4:5];
        nb_nxt    = '0;
        cnt_nxt   = '0;
        res_nxt   = '{prime_count: '0, is_prime: 1'b0};
      end
      ST_PCHK: begin
        if (mem_rdata[p_r[4:0]]) begin
          m_nxt     = pp_x;
          mem_raddr = pp_x[AW+4:5];
          first_nxt = 1'b1;
        end else begin
          p_nxt = p_r + PRIME_W'(1);
        end
      end
      ST_MCLR: begin
        if (mark_more && mark_same) begin
          // keep clearing within the held word
          wd_nxt    = mark_w_new;
          first_nxt = 1'b0;
          m_nxt     = m_step;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = m_r[AW+4:5];
          mem_wdata = mark_w_new;
          if (mark_more) begin
            mem_raddr = m_step[AW+4:5];
            first_nxt = 1'b1;
            m_nxt     = m_step;
          end else begin
            p_nxt = p_r + PRIME_W'(1);
          end
        end
      end
      ST_CRD: mem_raddr = nb_r[AW+4:5];
      ST_CACC: begin
        cnt_nxt = cnt_r + CNT_W'(popcount32(mem_rdata & cnt_mask));
        nb_nxt  = nb_step;
        res_nxt = '{prime_count: cnt_nxt, is_prime: 1'b0};
      end
      ST_TRD: mem_raddr = value_x[AW+4:5];
      ST_TCHK: begin
        res_nxt = '{prime_count: '0,
                    is_prime: filled_r && (value_x < TOTAL_BITS) && mem_rdata[val_r[4:0]]};
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      filled_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      filled_r <= filled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    m_r     <= m_nxt;
    top_r   <= top_nxt;
    ctop_r  <= ctop_nxt;
    nb_r    <= nb_nxt;
    fidx_r  <= fidx_nxt;
    val_r   <= val_nxt;
    wd_r    <= wd_nxt;
    first_r <= first_nxt;
    cnt_r   <= cnt_nxt;
    res_r   <= res_nxt;
  end

endmodule

FILE: rtl/core/prime_sieve_bitmap_top.sv
// ----------------------------------------------------------------------------
// prime_sieve_bitmap_top
// Primality bitmap built by the sieve of Eratosthenes, with a per-value test.
// ----------------------------------------------------------------------------
// Use:
//   One word in on the in_ channel (in_command, in_limit, in_value), one word
//   out on the out_ channel (out_prime_count, out_is_prime). Both channels use
//   valid/stall; a word moves when valid is high and stall is low.
//   A sieve word (command 0) refills the whole bitmap, clears every multiple of
//   each prime up to in_limit and returns the count of primes below in_limit.
//   A test word (command 1) returns the stored bit of in_value.
// Sequencing (one word at a time):
//   test:  a read state, a check state, then done; the result passes to the
//          output register and the next word is taken once the sequencer idles.
//   sieve: a fill pass over all BITMAP_WORDS words, a read and a check of each
//          candidate p with p*p <= in_limit, a clearing walk over the multiples
//          of each p still marked prime (the held word is written back as the
//          walk leaves it), then a read and an accumulate per word below in_limit.
//          The single RAM port pair paces all of it.
// Reset: control state clears; the bitmap reads as all zeros until the first
//   sieve, tracked by a fill flag, so no clearing pass runs.
// Stall: a finished result waits in the output register; the next word is
//   accepted meanwhile, but its own result holds until the register frees.
// ----------------------------------------------------------------------------
module prime_sieve_bitmap_top
  import psb_pkg::*;
#(
  parameter int BITMAP_WORDS = 2048
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_command,
  input  logic [15:0]      in_limit,
  input  logic [15:0]      in_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [12:0]      out_prime_count,
  output logic             out_is_prime
);

  localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  logic              res_valid;
  res_t              res;
  logic              slot_free;

  logic              out_valid_r, out_valid_nxt;
  res_t              out_r, out_nxt;

  psb_sieve_ctrl #(
    .BITMAP_WORDS (BITMAP_WORDS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_limit   (in_limit),
    .in_value   (in_value),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (slot_free),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // bitmap store: bit n%32 of word n/32 belongs to number n
  psb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BITMAP_WORDS)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // output register: free when empty or being taken this cycle
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (slot_free) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_prime_count = out_r.prime_count;
  assign out_is_prime    = out_r.is_prime;

endmodule

FILE: tb/prime_sieve_bitmap_checker.sv
// ----------------------------------------------------------------------------
// prime_sieve_bitmap_checker
// Watches both channels of the sieve block, predicts each result word from
// its own copy of the primality bitmap and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_sieve_bitmap_checker
  import psb_pkg::*;
#(
  parameter int BITMAP_WORDS = 2048
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             in_command,
  input  logic [15:0]      in_limit,
  input  logic [15:0]      in_value,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [12:0]      out_prime_count,
  input  logic             out_is_prime,
  output int               mismatches,
  output int               outstanding
);

  localparam int unsigned TOTAL_BITS = BITMAP_WORDS * WORD_W;

  bit   prime_map [TOTAL_BITS];
  res_t answers_due [$];

  // Refill the map, strike multiples up to the limit, count primes below it.
  function automatic logic [CNT_W-1:0] sieve_and_count(input int unsigned lim);
    int unsigned top_n;
    int unsigned p;
    int unsigned m;
    int unsigned n;
    int unsigned cnt;
    top_n = (lim > TOTAL_BITS - 1) ? TOTAL_BITS - 1 : lim;
    for (n = 0; n < TOTAL_BITS; n++) prime_map[n] = 1'b1;
    prime_map[0] = 1'b0;
    prime_map[1] = 1'b0;
    for (p = 2; p * p <= top_n; p++) begin
      if (prime_map[p]) begin
        for (m = p * p; m <= top_n; m += p) prime_map[m] = 1'b0;
      end
    end
    cnt = 0;
    for (n = 0; n < lim && n < TOTAL_BITS; n++) begin
      if (prime_map[n]) cnt++;
    end
    return cnt[CNT_W-1:0];
  endfunction

  function automatic res_t primality_answer(input logic cmd, input logic [15:0] lim,
                                            input logic [15:0] val);
    res_t r;
    r = '0;
    if (cmd == CMD_SIEVE) begin
      r.prime_count = sieve_and_count(lim);
    end else begin
      r.is_prime = (val < TOTAL_BITS) ? prime_map[val] : 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      foreach (prime_map[i]) prime_map[i] = 1'b0;
      answers_due.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      // result first: a word accepted at this edge cannot answer yet
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          $error("result word with nothing expected: prime_count %0d is_prime %0d",
                 out_prime_count, out_is_prime);
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          if (out_prime_count !== want.prime_count) begin
            $error("prime_count: expected %0d, actual %0d", want.prime_count,
                   out_prime_count);
            mismatches++;
          end
          if (out_is_prime !== want.is_prime) begin
            $error("is_prime: expected %0d, actual %0d", want.is_prime, out_is_prime);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        answers_due.push_back(primality_answer(in_command, in_limit, in_value));
      end
      outstanding <= answers_due.size();
    end
  end

endmodule

FILE: tb/prime_sieve_bitmap_top_tb.sv
// ----------------------------------------------------------------------------
// prime_sieve_bitmap_top_tb
// Drives sieve and test words into the sieve block with random gaps and
// output stalls; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_sieve_bitmap_top_tb;
  import psb_pkg::*;

  localparam int BITMAP_WORDS = 2048;
  localparam int RANDOM_WORDS = 100;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [15:0] in_limit;
  logic [15:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic [12:0] out_prime_count;
  logic        out_is_prime;

  int mismatches;
  int outstanding;

  // when set, neither side idles: gives stretches of back-to-back traffic
  bit calm;

  prime_sieve_bitmap_top #(
    .BITMAP_WORDS(BITMAP_WORDS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_limit       (in_limit),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_prime_count(out_prime_count),
    .out_is_prime   (out_is_prime)
  );

  prime_sieve_bitmap_checker #(
    .BITMAP_WORDS(BITMAP_WORDS)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_limit       (in_limit),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_prime_count(out_prime_count),
    .out_is_prime   (out_is_prime),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Length of one idle stretch: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(5, 60);
  endfunction

  // Offer one word, after an optional gap, and hold it until it is taken.
  // Called at a rising edge; returns at the edge where the word moved.
  task automatic send_word(input logic cmd, input logic [15:0] lim,
                           input logic [15:0] val);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      // drop valid and scramble the idle payload so it must be ignored
      in_valid   <= 1'b0;
      in_command <= 1'($urandom);
      in_limit   <= 16'($urandom);
      in_value   <= 16'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_limit   <= lim;
    in_value   <= val;
    @(posedge clk);
    // hold the payload steady while stalled
    while (in_stall) @(posedge clk);
  endtask

  // Receiver side: stall in random bursts, independent of out_valid.
  initial begin : receiver
    int run;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      run = idle_len();
      if (run == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        repeat (run) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Hard stop: the slowest legal run (one full-range sieve, up to three more
  // reaching into the upper half, every other word a sieve of up to 2047,
  // plus stalls) stays well inside this limit.
  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int          r;
    int          hi;
    int          big_left;
    logic [15:0] last_lim;
    logic [15:0] lim;
    logic [15:0] val;

    calm       = 1'b0;
    in_valid   <= 1'b0;
    in_command <= CMD_SIEVE;
    in_limit   <= '0;
    in_value   <= '0;
    rst_n      <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // Tests before any sieve read the reset store: every bit zero.
    send_word(CMD_TEST, 16'($urandom), 16'd0);
    send_word(CMD_TEST, 16'($urandom), 16'd65535);
    send_word(CMD_TEST, 16'($urandom), 16'd2);

    // Limit zero: store set, 0 and 1 cleared, nothing struck, count zero.
    // Everything from 2 upward then reads as one, composites included.
    send_word(CMD_SIEVE, 16'd0, 16'($urandom));
    send_word(CMD_TEST, 16'($urandom), 16'd0);
    send_word(CMD_TEST, 16'($urandom), 16'd1);
    send_word(CMD_TEST, 16'($urandom), 16'd2);
    send_word(CMD_TEST, 16'($urandom), 16'd4);

    // Limits one to three: still nothing struck; the count is strictly below.
    send_word(CMD_SIEVE, 16'd1, 16'($urandom));
    send_word(CMD_TEST, 16'($urandom), 16'd1);
    send_word(CMD_SIEVE, 16'd2, 16'($urandom));
    send_word(CMD_TEST, 16'($urandom), 16'd2);
    send_word(CMD_SIEVE, 16'd3, 16'($urandom));
    send_word(CMD_TEST, 16'($urandom), 16'd3);

    // Limit is inclusive for striking: 100 itself is cleared, 102 is not.
    send_word(CMD_SIEVE, 16'd100, 16'($urandom));
    send_word(CMD_TEST, 16'($urandom), 16'd97);
    send_word(CMD_TEST, 16'($urandom), 16'd100);
    send_word(CMD_TEST, 16'($urandom), 16'd101);
    send_word(CMD_TEST, 16'($urandom), 16'd102);

    // Full range once: largest prime below 2^16, and the top composites.
    send_word(CMD_SIEVE, 16'd65535, 16'($urandom));
    send_word(CMD_TEST, 16'($urandom), 16'd65521);
    send_word(CMD_TEST, 16'($urandom), 16'd65534);
    send_word(CMD_TEST, 16'($urandom), 16'd65535);
    send_word(CMD_TEST, 16'($urandom), 16'd0);

    // ---- random part ----
    // Sieves mostly with small limits (the fill alone costs a full pass);
    // at most three reach into the upper half. Tests cluster around the
    // last limit so both struck and untouched bits get read.
    last_lim = 16'd65535;
    big_left = 3;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 20 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 28) begin
        if (big_left > 0 && $urandom_range(0, 29) == 0) begin
          lim = 16'($urandom_range(32768, 65535));
          big_left--;
        end else if ($urandom_range(0, 9) == 0) begin
          lim = 16'($urandom_range(0, 40));
        end else begin
          lim = 16'($urandom_range(0, 2047));
        end
        last_lim = lim;
        send_word(CMD_SIEVE, lim, 16'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          hi = int'(last_lim) + 40;
          if (hi > 65535) hi = 65535;
          val = 16'($urandom_range(0, hi));
        end else if (r < 90) begin
          val = 16'($urandom);
        end else begin
          val = 16'($urandom_range(0, 3));
        end
        send_word(CMD_TEST, 16'($urandom), val);
      end
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // Drain: wait until every expected word is back, then linger a little
    // to catch any stray result.
    do @(posedge clk); while (outstanding != 0);
    repeat (64) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
